// ===== rtl/core/b2b_pkg.sv =====
// b2b_pkg: constants, types and helper functions for the blake2b hash engine
// used by b2b_round, blake2b_hash_engine and the testbench; no dependencies
`timescale 1ns / 1ps
package b2b_pkg;

	localparam logic [1:0] CFG_DIGEST   = 2'd0;
	localparam logic [1:0] CFG_KEY      = 2'd1;
	localparam logic [1:0] CFG_PERS_LO  = 2'd2;
	localparam logic [1:0] CFG_PERS_HI  = 2'd3;

	localparam logic [63:0] PARAM_CONST = 64'h0000_0000_0101_0000;
	localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef logic [63:0] word_t;

	// round unit status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} rnd_stat_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		r = '0;
		case (i)
			3'd0: r = 64'h6a09e667f3bcc908;
			3'd1: r = 64'hbb67ae8584caa73b;
			3'd2: r = 64'h3c6ef372fe94f82b;
			3'd3: r = 64'ha54ff53a5f1d36f1;
			3'd4: r = 64'h510e527fade682d1;
			3'd5: r = 64'h9b05688c2b3e6c1f;
			3'd6: r = 64'h1f83d9abfb41bd6b;
			3'd7: r = 64'h5be0cd19137e2179;
			default: r = '0;
		endcase
		return r;
	endfunction

	// message schedule: round mod 10, slot 0..15
	function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] s);
		logic [63:0] row;
		row = '0;
		case (r)
			4'd0: row = 64'hfedcba9876543210;
			4'd1: row = 64'h357b20c16df984ae;
			4'd2: row = 64'h491763eadf250c8b;
			4'd3: row = 64'h8f04a562ebcd1397;
			4'd4: row = 64'hd386cb1efa427509;
			4'd5: row = 64'h91ef57d438b0a6c2;
			4'd6: row = 64'hb8293670a4def15c;
			4'd7: row = 64'ha2684f05931ce7bd;
			4'd8: row = 64'h5a417d2c803b9ef6;
			4'd9: row = 64'h0dc3e9bf5167482a;
			default: row = '0;
		endcase
		return row[s*4 +: 4];
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

endpackage

// ===== rtl/core/b2b_stream_if.sv =====
// b2b_stream_if: valid/ready channel carrying the hash engine payloads
// no dependencies
`timescale 1ns / 1ps
interface b2b_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        end_of_message;
	modport source (output valid, data_word, byte_count, end_of_message, input ready);
	modport sink (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface b2b_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [3:0]  digest_valid_bytes;
	logic        last_word;
	modport source (output valid, digest_word, digest_valid_bytes, last_word, input ready);
	modport sink (input valid, digest_word, digest_valid_bytes, last_word, output ready);
endinterface

// ===== rtl/core/b2b_round.sv =====
// b2b_round: compression unit, one G function per pass through RDX, RDY and MIX over a 16-word work memory
// depends on b2b_pkg; message words read from the block buffer memory via mw_addr/mw_data
`timescale 1ns / 1ps
module b2b_round (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  b2b_pkg::word_t      init_v [16],
	output logic [3:0]          mw_addr,
	input  b2b_pkg::word_t      mw_data,
	output b2b_pkg::word_t      v_out [16],
	output b2b_pkg::rnd_stat_t  stat
);
	import b2b_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RDX  = 2'd1;
	localparam logic [1:0] ST_RDY  = 2'd2;
	localparam logic [1:0] ST_MIX  = 2'd3;

	logic [1:0] state_q;
	logic [3:0] round_q;
	logic [3:0] sround_q;
	logic [2:0] g_q;
	word_t      v_q [16];
	logic [3:0] ia, ib, ic, id;
	word_t      a1, d1, c1, b1, a2, d2, c2, b2;

	always_comb begin
		ia = {2'b00, g_q[1:0]};
		if (!g_q[2]) begin
			ib = 4'd4 + {2'b00, g_q[1:0]};
			ic = 4'd8 + {2'b00, g_q[1:0]};
			id = 4'd12 + {2'b00, g_q[1:0]};
		end else begin
			ib = 4'd4 + {2'b00, g_q[1:0] + 2'd1};
			ic = 4'd8 + {2'b00, g_q[1:0] + 2'd2};
			id = 4'd12 + {2'b00, g_q[1:0] + 2'd3};
		end
	end

	always_comb begin
		mw_addr = sigma(sround_q, {g_q, state_q == ST_RDY});
		if (state_q == ST_IDLE)
			mw_addr = sigma(4'd0, 4'd0);
		a1 = v_q[ia] + v_q[ib] + mw_data;
		d1 = rotr(v_q[id] ^ a1, 32);
		c1 = v_q[ic] + d1;
		b1 = rotr(v_q[ib] ^ c1, 24);
		a2 = v_q[ia] + v_q[ib] + mw_data;
		d2 = rotr(v_q[id] ^ a2, 16);
		c2 = v_q[ic] + d2;
		b2 = rotr(v_q[ib] ^ c2, 63);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			sround_q <= '0;
			g_q <= '0;
			stat <= '0;
		end else begin
			stat.done <= (state_q == ST_MIX) && (g_q == 3'd7) && (round_q == 4'd11);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RDX;
						round_q <= '0;
						sround_q <= '0;
						g_q <= '0;
						stat.busy <= 1'b1;
					end
				end
				ST_RDX: state_q <= ST_RDY;
				ST_RDY: state_q <= ST_MIX;
				ST_MIX: begin
					g_q <= g_q + 3'd1;
					if (g_q == 3'd7 && round_q == 4'd11) begin
						state_q <= ST_IDLE;
						stat.busy <= 1'b0;
					end else
						state_q <= ST_RDX;
					if (g_q == 3'd7) begin
						round_q <= round_q + 4'd1;
						sround_q <= (sround_q == 4'd9) ? 4'd0 : sround_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// first half of g while x is on the read port, second half while y is
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			for (int i = 0; i < 16; i++) v_q[i] <= init_v[i];
		end
		if (state_q == ST_RDY) begin
			v_q[ia] <= a1;
			v_q[ib] <= b1;
			v_q[ic] <= c1;
			v_q[id] <= d1;
		end
		if (state_q == ST_MIX) begin
			v_q[ia] <= a2;
			v_q[ib] <= b2;
			v_q[ic] <= c2;
			v_q[id] <= d2;
		end
	end

	assign v_out = v_q;

endmodule

// ===== rtl/core/blake2b_hash_engine.sv =====
// blake2b_hash_engine: byte-stream blake2b with block buffer memory and digest output
// a request is absorbed byte by byte, each byte read, then modified and written; no new request is taken meanwhile
// compression: a start state, 12 rounds of 8 g functions in the round unit, then a 16-word block buffer clear
// digest words follow end of message after the final compression, one per cycle while out_req.ready is high
// asynchronous active-low reset, then a clear of all 16 block buffer words before the first request
// depends on b2b_pkg, b2b_stream_if, b2b_round
`timescale 1ns / 1ps
module blake2b_hash_engine (
	input  logic         clk,
	input  logic         arst_n,
	b2b_in_if.sink       in_req,
	b2b_out_if.source    out_req,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import b2b_pkg::*;

	localparam logic [2:0] ST_IN    = 3'd0;
	localparam logic [2:0] ST_BYTE  = 3'd1;
	localparam logic [2:0] ST_COMP  = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_CLR   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]  state_q;
	logic [6:0]  dig_q, key_q;
	word_t       plo_q, phi_q;
	word_t       h_q [8];
	logic [7:0]  fill_q;
	logic [63:0] len_lo_q, len_hi_q;
	logic        pend_q;
	logic        final_q;
	logic        after_q;
	word_t       word_q;
	logic [3:0]  cnt_q;
	logic [3:0]  bi_q;
	logic        eom_q;
	logic [3:0]  clr_q;
	logic [2:0]  oi_q;

	word_t       buf_mem [16];
	word_t       rd_data;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [3:0]  wr_addr;
	word_t       wr_data;

	word_t       init_v [16];
	word_t       v_out [16];
	logic [3:0]  mw_addr;
	rnd_stat_t   rstat;
	logic        rstart;

	logic [6:0]  dlen;
	logic [6:0]  klen;
	logic [2:0]  nw_last;
	logic [6:0]  rem;
	word_t       h0_init;
	logic        fresh;
	logic [7:0]  bcur;
	logic [127:0] len_sum;

	always_comb begin
		dlen = (dig_q == 7'd0) ? 7'd1 : ((dig_q > 7'd64) ? 7'd64 : dig_q);
		klen = (key_q > 7'd64) ? 7'd64 : key_q;
		nw_last = 3'((dlen - 7'd1) >> 3);
		h0_init = iv_word(3'd0) ^ PARAM_CONST ^ {49'd0, klen, 8'd0} ^ {57'd0, dlen};
		fresh = (fill_q == 8'd0) && !pend_q && (len_lo_q == '0) && (len_hi_q == '0);
		rem = dlen - {1'b0, oi_q, 3'b000};
		bcur = word_q[bi_q[2:0]*8 +: 8];
		len_sum = {len_hi_q, len_lo_q} + (pend_q ? 128'd128 : {120'd0, fill_q});
	end

	// memory port muxing: round unit owns the read port while compressing
	always_comb begin
		rd_addr = fill_q[6:3];
		if (state_q == ST_COMP || state_q == ST_WAIT)
			rd_addr = mw_addr;
		wr_en = 1'b0;
		wr_addr = fill_q[6:3];
		wr_data = rd_data;
		if (state_q == ST_BYTE && !pend_q && bi_q < cnt_q && after_q) begin
			wr_en = 1'b1;
			wr_data[fill_q[2:0]*8 +: 8] = bcur;
		end
		if (state_q == ST_CLR) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			buf_mem[wr_addr] <= wr_data;
		rd_data <= (wr_en && wr_addr == rd_addr) ? wr_data : buf_mem[rd_addr];
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			init_v[i] = h_q[i];
			init_v[i+8] = iv_word(3'(i));
		end
		init_v[12] = iv_word(3'd4) ^ len_sum[63:0];
		init_v[13] = iv_word(3'd5) ^ len_sum[127:64];
		init_v[14] = iv_word(3'd6) ^ (final_q ? ALL_ONES : '0);
	end

	assign rstart = (state_q == ST_COMP);

	b2b_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rstart),
		.init_v (init_v),
		.mw_addr(mw_addr),
		.mw_data(rd_data),
		.v_out  (v_out),
		.stat   (rstat)
	);

	assign in_req.ready = (state_q == ST_IN);
	assign out_req.valid = (state_q == ST_OUT);
	always_comb begin
		out_req.digest_word = h_q[oi_q];
		out_req.digest_valid_bytes = (rem >= 7'd8) ? 4'd8 : 4'(rem);
		for (int b = 0; b < 8; b++)
			if (rem < 7'd8 && 7'(b) >= rem)
				out_req.digest_word[b*8 +: 8] = 8'd0;
		out_req.last_word = (oi_q == nw_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			dig_q <= 7'd64;
			key_q <= '0;
			plo_q <= '0;
			phi_q <= '0;
			for (int i = 1; i < 8; i++) h_q[i] <= iv_word(3'(i));
			h_q[0] <= iv_word(3'd0) ^ PARAM_CONST ^ 64'd64;
			fill_q <= '0;
			len_lo_q <= '0;
			len_hi_q <= '0;
			pend_q <= 1'b0;
			final_q <= 1'b0;
			after_q <= 1'b0;
			word_q <= '0;
			cnt_q <= '0;
			bi_q <= '0;
			eom_q <= 1'b0;
			clr_q <= '0;
			oi_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIGEST:  dig_q <= cfg_data[6:0];
					CFG_KEY:     key_q <= cfg_data[6:0];
					CFG_PERS_LO: plo_q <= cfg_data;
					CFG_PERS_HI: phi_q <= cfg_data;
					default: ;
				endcase
			end else if (fresh && state_q == ST_IN) begin
				h_q[0] <= h0_init;
				h_q[6] <= iv_word(3'd6) ^ plo_q;
				h_q[7] <= iv_word(3'd7) ^ phi_q;
			end
			unique case (state_q)
				ST_IN: begin
					if (in_req.valid) begin
						word_q <= in_req.data_word;
						cnt_q <= (in_req.byte_count > 4'd8) ? 4'd8 : in_req.byte_count;
						eom_q <= in_req.end_of_message;
						bi_q <= '0;
						after_q <= 1'b0;
						state_q <= ST_BYTE;
					end
				end
				ST_BYTE: begin
					// each byte is read, then modified and written
					if (bi_q >= cnt_q) begin
						if (eom_q) begin
							final_q <= 1'b1;
							state_q <= ST_COMP;
						end else
							state_q <= ST_IN;
					end else if (pend_q) begin
						final_q <= 1'b0;
						state_q <= ST_COMP;
					end else if (!after_q) begin
						after_q <= 1'b1;
					end else begin
						after_q <= 1'b0;
						bi_q <= bi_q + 4'd1;
						fill_q <= fill_q + 8'd1;
						if (fill_q == 8'd127) pend_q <= 1'b1;
					end
				end
				ST_COMP: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (rstat.done) begin
						for (int i = 0; i < 8; i++)
							h_q[i] <= h_q[i] ^ v_out[i] ^ v_out[i+8];
						{len_hi_q, len_lo_q} <= len_sum;
						fill_q <= '0;
						pend_q <= 1'b0;
						clr_q <= '0;
						oi_q <= '0;
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 4'd1;
					if (clr_q == 4'd15) begin
						if (final_q)
							state_q <= ST_OUT;
						else if (eom_q || bi_q < cnt_q)
							state_q <= ST_BYTE;
						else
							state_q <= ST_IN;
					end
				end
				ST_OUT: begin
					if (out_req.ready) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == nw_last) begin
							final_q <= 1'b0;
							eom_q <= 1'b0;
							cnt_q <= '0;
							bi_q <= '0;
							len_lo_q <= '0;
							len_hi_q <= '0;
							h_q[0] <= h0_init;
							for (int i = 1; i < 6; i++) h_q[i] <= iv_word(3'(i));
							h_q[6] <= iv_word(3'd6) ^ plo_q;
							h_q[7] <= iv_word(3'd7) ^ phi_q;
							state_q <= ST_IN;
						end
					end
				end
				default: state_q <= ST_IN;
			endcase
		end
	end

endmodule

// ===== rtl/core/b2b_checker.sv =====
// b2b_checker: port-level assertions for blake2b_hash_engine
// depends on b2b_stream_if; bound to the top level
`timescale 1ns / 1ps
module b2b_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  out_bytes,
	input logic        out_last,
	input logic [63:0] out_word
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while digest pending");
	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_bytes != 4'd0 && out_bytes <= 4'd8))
		else $error("digest byte count out of range");
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_bytes != 4'd8) |-> out_last)
		else $error("short digest word not last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
		else $error("digest dropped under stall");
endmodule

bind blake2b_hash_engine b2b_checker u_b2b_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_req.valid),
	.in_ready (in_req.ready),
	.out_valid(out_req.valid),
	.out_ready(out_req.ready),
	.out_bytes(out_req.digest_valid_bytes),
	.out_last (out_req.last_word),
	.out_word (out_req.digest_word)
);

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for blake2b_hash_engine, predicts each digest with a
// bytewise blake2b model and compares every digest word; depends on b2b_pkg,
// b2b_stream_if and the engine rtl
`timescale 1ns / 1ps
module tb;
	import b2b_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	localparam logic [63:0] HASH_IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
	localparam logic [3:0] MSG_PERM [10][16] = '{
		'{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
		'{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
		'{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
		'{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
		'{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
		'{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
		'{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
		'{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
		'{6,15,14,9,11,3,0,8,12,2,13,7,1,4,10,5},
		'{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0}};
	localparam int MIX_A [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
	localparam int MIX_B [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
	localparam int MIX_C [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
	localparam int MIX_D [8] = '{12, 13, 14, 15, 15, 12, 13, 14};

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} digest_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;

	b2b_in_if  in_req ();
	b2b_out_if out_req ();

	blake2b_hash_engine u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_req   (in_req.sink),
		.out_req  (out_req.source),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predicted engine state
	logic [6:0]   reg_digest, reg_key;
	logic [63:0]  reg_pers_lo, reg_pers_hi;
	logic [63:0]  chain [8];
	logic [63:0]  blk [16];
	int           fill;
	logic [127:0] byte_total;
	bit           blk_held;

	digest_beat_t digest_q [$];
	int errors;
	int send_idle_pct, recv_stall_pct, hold_left, stall_count;

	function automatic logic [63:0] rot_right(input logic [63:0] x, input int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	function automatic int digest_len();
		if (reg_digest == 0) return 1;
		if (reg_digest > 64) return 64;
		return reg_digest;
	endfunction

	task automatic init_message();
		logic [63:0] kb;
		kb = (reg_key > 64) ? 64'd64 : 64'(reg_key);
		for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
		chain[0] ^= PARAM_CONST ^ (kb << 8) ^ 64'(digest_len());
		chain[6] ^= reg_pers_lo;
		chain[7] ^= reg_pers_hi;
		for (int i = 0; i < 16; i++) blk[i] = '0;
		fill = 0;
		byte_total = '0;
		blk_held = 0;
	endtask

	task automatic compress_block(input bit final_blk);
		logic [63:0] v [16];
		int a, b, c, d;
		logic [3:0] s [16];
		for (int i = 0; i < 8; i++) begin
			v[i] = chain[i];
			v[i + 8] = HASH_IV[i];
		end
		v[12] ^= byte_total[63:0];
		v[13] ^= byte_total[127:64];
		if (final_blk) v[14] ^= ALL_ONES;
		for (int r = 0; r < 12; r++) begin
			s = MSG_PERM[r % 10];
			for (int g = 0; g < 8; g++) begin
				a = MIX_A[g]; b = MIX_B[g]; c = MIX_C[g]; d = MIX_D[g];
				v[a] = v[a] + v[b] + blk[s[2*g]];
				v[d] = rot_right(v[d] ^ v[a], 32);
				v[c] = v[c] + v[d];
				v[b] = rot_right(v[b] ^ v[c], 24);
				v[a] = v[a] + v[b] + blk[s[2*g+1]];
				v[d] = rot_right(v[d] ^ v[a], 16);
				v[c] = v[c] + v[d];
				v[b] = rot_right(v[b] ^ v[c], 63);
			end
		end
		for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i + 8];
		for (int i = 0; i < 16; i++) blk[i] = '0;
		fill = 0;
		blk_held = 0;
	endtask

	task automatic absorb_request(input logic [63:0] w, input logic [3:0] cnt, input logic eom);
		int n, dlen, nwords, valid;
		digest_beat_t beat;
		n = (cnt > 8) ? 8 : cnt;
		for (int i = 0; i < n; i++) begin
			if (blk_held) begin
				byte_total += 128'd128;
				compress_block(0);
			end
			blk[fill / 8][(fill % 8) * 8 +: 8] = w[i * 8 +: 8];
			fill++;
			if (fill == 128) blk_held = 1;
		end
		if (eom) begin
			byte_total += 128'(fill);
			compress_block(1);
			dlen = digest_len();
			nwords = (dlen + 7) / 8;
			for (int i = 0; i < nwords; i++) begin
				valid = (dlen - i * 8 > 8) ? 8 : dlen - i * 8;
				beat.word = chain[i];
				if (valid < 8) beat.word &= (64'd1 << (valid * 8)) - 64'd1;
				beat.nbytes = 4'(valid);
				beat.last = (i + 1 == nwords);
				digest_q.push_back(beat);
			end
			init_message();
		end
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// request monitor feeds the predictor
	always @(posedge clk)
		if (in_req.valid && in_req.ready)
			absorb_request(in_req.data_word, in_req.byte_count, in_req.end_of_message);

	// digest checker
	always @(posedge clk) begin
		digest_beat_t exp_beat;
		if (out_req.valid && out_req.ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest word %h", $time, out_req.digest_word);
				errors++;
			end else begin
				exp_beat = digest_q.pop_front();
				if (exp_beat.word !== out_req.digest_word ||
						exp_beat.nbytes !== out_req.digest_valid_bytes ||
						exp_beat.last !== out_req.last_word) begin
					$display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
						$time, exp_beat.word, exp_beat.nbytes, exp_beat.last,
						out_req.digest_word, out_req.digest_valid_bytes, out_req.last_word);
					errors++;
				end
			end
		end
	end

	// receiver with random stalls and long hold-offs
	initial begin
		out_req.ready = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_req.ready <= 0;
				hold_left--;
			end else begin
				out_req.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_req.valid && in_req.ready) || (out_req.valid && out_req.ready))
			stall_count = 0;
		else if (in_req.valid || digest_q.size() != 0)
			stall_count++;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("blake2b_hash_engine test failed");
			$finish;
		end
	end

	task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic eom);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_req.valid <= 0;
			@(posedge clk);
		end
		in_req.valid <= 1;
		in_req.data_word <= w;
		in_req.byte_count <= cnt;
		in_req.end_of_message <= eom;
		@(posedge clk);
		while (!in_req.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_req.valid <= 0;
		@(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			CFG_DIGEST:  reg_digest = val[6:0];
			CFG_KEY:     reg_key = val[6:0];
			CFG_PERS_LO: reg_pers_lo = val;
			CFG_PERS_HI: reg_pers_hi = val;
			default: ;
		endcase
		init_message();
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// full words, then a tail of the given count with end of message
	task automatic send_message(input int nwords, input logic [3:0] tail);
		for (int i = 0; i < nwords; i++) send_word(rand_word(), 4'd8, 0);
		send_word(rand_word(), tail, 1);
	endtask

	task automatic test_directed();
		send_word(64'h0, 4'd0, 1);
		send_word(64'h0000_0000_0063_6261, 4'd3, 1);
		send_word(ALL_ONES, 4'd5, 0);
		send_word(ALL_ONES, 4'd15, 0);
		send_word(64'h0, 4'd8, 1);
		send_message(15, 4'd0);
		wait_drained();
		write_reg(CFG_DIGEST, 64'd1);
		write_reg(CFG_PERS_LO, ALL_ONES);
		write_reg(CFG_PERS_HI, ALL_ONES);
		send_word(ALL_ONES, 4'd8, 1);
		wait_drained();
		write_reg(CFG_DIGEST, 64'd0);
		write_reg(CFG_KEY, 64'd64);
		send_message(16, 4'd9);
		wait_drained();
		write_reg(CFG_DIGEST, 64'd127);
		write_reg(CFG_KEY, 64'd100);
		send_word(64'h8000_0000_0000_0001, 4'd1, 1);
		wait_drained();
	endtask

	task automatic random_config();
		case ($urandom_range(0, 3))
			0: write_reg(CFG_DIGEST, 64'd64);
			1: write_reg(CFG_DIGEST, 64'($urandom_range(0, 127)));
			default: write_reg(CFG_DIGEST, 64'($urandom_range(1, 64)));
		endcase
		write_reg(CFG_KEY, $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(0, 127)));
		write_reg(CFG_PERS_LO, $urandom_range(0, 2) ? rand_word() : 64'd0);
		write_reg(CFG_PERS_HI, $urandom_range(0, 2) ? rand_word() : 64'd0);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int target);
		int sent, n;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		random_config();
		sent = 0;
		while (sent < target) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 18);
			for (int i = 0; i < n; i++)
				send_word(rand_word(), ($urandom_range(0, 9) == 0) ?
					4'($urandom_range(0, 15)) : 4'd8, 0);
			send_word(rand_word(), 4'($urandom_range(0, 15)), 1);
			sent += n + 1;
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(CFG_DIGEST, 64'd64);
		hold_left = 3000;
		for (int m = 0; m < 6; m++) send_message(1, 4'd8);
		wait_drained();
	endtask

	initial begin
		errors = 0;
		stall_count = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_DIGEST;
		cfg_data = '0;
		in_req.valid = 0;
		in_req.data_word = '0;
		in_req.byte_count = '0;
		in_req.end_of_message = 0;
		reg_digest = 7'd64;
		reg_key = '0;
		reg_pers_lo = '0;
		reg_pers_hi = '0;
		init_message();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		test_directed();
		test_random(0, 0, 35);
		test_random(57, 0, 35);
		test_random(0, 57, 35);
		test_random(16, 16, 35);
		test_backpressure();

		if (errors == 0) begin
			$display("blake2b_hash_engine test passed");
		end else begin
			$display("blake2b_hash_engine test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/b2b_pkg.sv
rtl/core/b2b_stream_if.sv
rtl/core/b2b_round.sv
rtl/core/blake2b_hash_engine.sv
rtl/core/b2b_checker.sv
tb/sv/tb.sv
